FILE: sv/nvbs_pkg.sv
// Shared constants, codes and controller-to-datapath types of the nearest-value search.
`default_nettype none
package nvbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int VAL_W       = 32;
	localparam int DIST_W      = VAL_W + 1;
	localparam int STATUS_W    = 2;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_LOAD_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ANSWERED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE_ERR = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // write the entry and post a load result
		logic query;     // capture range and key, issue the first probe
		logic range_err; // post a range error result
		logic narrow;    // move to the half below or above the probe
		logic take_mid;  // post the probe as an exact hit
		logic take_lo;   // post the single remaining entry
		logic read_hi;   // keep the lower distance and read the upper entry
		logic dist_hi;   // keep the upper distance
		logic decide;    // post the nearer of the last two entries
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_bad; // incoming request has low above high
		logic hit;       // probed entry equals the key
		logic wide;      // more than two entries remain
		logic single;    // exactly one entry remains
	} dp_status_t;

endpackage
`default_nettype wire

FILE: sv/nvbs_dpath.sv
// Datapath of the nearest-value search: table memory, bounds, distances and result registers.
`default_nettype none
module nvbs_dpath (
	input  wire logic                             clk,
	input  wire nvbs_pkg::dp_cmd_t                cmd,
	output nvbs_pkg::dp_status_t                  stat,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       load_index,
	input  wire logic [nvbs_pkg::VAL_W-1:0]       load_value,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       range_low,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       range_high,
	input  wire logic signed [nvbs_pkg::VAL_W-1:0] search_key,
	output logic [nvbs_pkg::STATUS_W-1:0]         status,
	output logic [nvbs_pkg::IDX_W-1:0]            found_index,
	output logic                                  exact_hit
);
	import nvbs_pkg::*;

	logic [VAL_W-1:0]        table_q [TABLE_DEPTH];
	logic [VAL_W-1:0]        rdata_q;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        lo_q, hi_q, mid_q;
	logic signed [VAL_W-1:0] key_q;
	logic [IDX_W-1:0]        lo_n, hi_n;
	logic [IDX_W:0]          sum_in, sum_n;
	logic [DIST_W-1:0]       diff, mag;
	logic [DIST_W-1:0]       dl_q, dh_q;
	logic                    eqh_q;
	logic                    lo_nearer;
	logic [STATUS_W-1:0]     status_q;
	logic [IDX_W-1:0]        found_q;
	logic                    exact_q;

	assign stat.range_bad = range_low > range_high;
	assign stat.hit       = $signed(rdata_q) == key_q;
	assign stat.wide      = (hi_q - lo_q) > IDX_W'(1);
	assign stat.single    = lo_q == hi_q;

	// The probe missed, so leave the midpoint out of the remaining range.
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if ($signed(rdata_q) > key_q) begin
			hi_n = mid_q - IDX_W'(1);
		end else begin
			lo_n = mid_q + IDX_W'(1);
		end
	end

	assign sum_in = {1'b0, range_low} + {1'b0, range_high};
	assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};

	always_comb begin
		rd_addr = mid_q;
		if (cmd.query) begin
			rd_addr = sum_in[IDX_W:1];
		end else if (cmd.narrow) begin
			rd_addr = sum_n[IDX_W:1];
		end else if (cmd.read_hi) begin
			rd_addr = hi_q;
		end
	end

	// Exact magnitude of entry minus key, one bit wider than a value.
	assign diff = {rdata_q[VAL_W-1], rdata_q} - {key_q[VAL_W-1], key_q};
	assign mag  = diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;

	assign lo_nearer = dl_q < dh_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			table_q[load_index] <= load_value;
		end
		rdata_q <= table_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			lo_q  <= range_low;
			hi_q  <= range_high;
			key_q <= search_key;
			mid_q <= sum_in[IDX_W:1];
		end else if (cmd.narrow) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= sum_n[IDX_W:1];
		end
		if (cmd.read_hi) begin
			dl_q <= mag;
		end
		if (cmd.dist_hi) begin
			dh_q  <= mag;
			eqh_q <= stat.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= ST_LOAD_DONE;
			found_q  <= '0;
			exact_q  <= 1'b0;
		end else if (cmd.range_err) begin
			status_q <= ST_RANGE_ERR;
			found_q  <= '0;
			exact_q  <= 1'b0;
		end else if (cmd.take_mid) begin
			status_q <= ST_ANSWERED;
			found_q  <= mid_q;
			exact_q  <= 1'b1;
		end else if (cmd.take_lo) begin
			status_q <= ST_ANSWERED;
			found_q  <= lo_q;
			exact_q  <= 1'b0;
		end else if (cmd.decide) begin
			status_q <= ST_ANSWERED;
			found_q  <= lo_nearer ? lo_q : hi_q;
			exact_q  <= !lo_nearer && eqh_q;
		end
	end

	assign status      = status_q;
	assign found_index = found_q;
	assign exact_hit   = exact_q;

endmodule
`default_nettype wire

FILE: sv/nvbs_ctrl.sv
// Controller of the nearest-value search: handshakes and the bisection state machine.
`default_nettype none
module nvbs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 mode,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire nvbs_pkg::dp_status_t stat,
	output nvbs_pkg::dp_cmd_t         cmd
);
	import nvbs_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_DISTHI = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q, state_n;
	logic       out_valid_q;
	logic       accept;
	logic       post;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_LOAD) begin
						cmd.load = 1'b1;
					end else if (stat.range_bad) begin
						cmd.range_err = 1'b1;
					end else begin
						cmd.query = 1'b1;
						state_n   = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				if (stat.hit) begin
					cmd.take_mid = 1'b1;
					state_n      = S_IDLE;
				end else if (stat.wide) begin
					cmd.narrow = 1'b1;
				end else if (stat.single) begin
					cmd.take_lo = 1'b1;
					state_n     = S_IDLE;
				end else begin
					cmd.read_hi = 1'b1;
					state_n     = S_DISTHI;
				end
			end
			S_DISTHI: begin
				cmd.dist_hi = 1'b1;
				state_n     = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_n    = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign post = cmd.load || cmd.range_err || cmd.take_mid || cmd.take_lo || cmd.decide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: sv/nearest_value_binary_search.sv
// Top level of the nearest-value search over a loaded table of ascending signed values.
`default_nettype none
//  channel  handshake            payload
//  in       in_valid / in_stall  mode, load_index, load_value, range_low, range_high, search_key
//  out      out_valid / out_stall  status, found_index, exact_hit
//
// A load request writes one table entry and answers in the cycle after acceptance.
// A query request probes the single-port table one entry at a time: at most eight
// probes over 256 entries, then a read of the upper entry and a comparison of the two
// distances when a final pair is left. One request is worked on at a time.
// Reset clears the controller only; the table holds no defined value until loaded.
// A result held back by out_stall stays in the output register and stalls the input.
module nearest_value_binary_search (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             mode,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       load_index,
	input  wire logic signed [nvbs_pkg::VAL_W-1:0] load_value,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       range_low,
	input  wire logic [nvbs_pkg::IDX_W-1:0]       range_high,
	input  wire logic signed [nvbs_pkg::VAL_W-1:0] search_key,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [nvbs_pkg::STATUS_W-1:0]         status,
	output logic [nvbs_pkg::IDX_W-1:0]            found_index,
	output logic                                  exact_hit
);
	import nvbs_pkg::*;

	// Commands run from the controller to the datapath, status flags back.
	dp_cmd_t    cmd;
	dp_status_t stat;

	// The controller owns the handshakes and the bisection sequence; it ends a
	// query on an exact hit, on a single remaining entry, or after comparing the
	// distances of the last two entries.
	nvbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the table, the search bounds, the key, the two distances
	// (exact magnitudes one bit wider than a value) and the result registers.
	nvbs_dpath u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.load_index  (load_index),
		.load_value  (load_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.search_key  (search_key),
		.status      (status),
		.found_index (found_index),
		.exact_hit   (exact_hit)
	);

endmodule
`default_nettype wire
